### rtl/voxel_greedy_mesher_assert.svh
// Assertion macros shared by the mesher RTL.
// Needs a clock named i_clk and a synchronous active-low reset i_rst_n in scope.
`ifndef VOXEL_GREEDY_MESHER_ASSERT_SVH
`define VOXEL_GREEDY_MESHER_ASSERT_SVH

// Same-cycle implication.
`define VGM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mesher assertion failed");

// Next-cycle implication.
`define VGM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mesher assertion failed");

`endif

### rtl/vgm_pkg.sv
// Shared types and constants for the voxel greedy mesher.
// No dependencies.
package vgm_pkg;

    localparam int CHUNK_SIZE_DEF = 16;

    localparam logic [1:0] FACE_NONE  = 2'd0;
    localparam logic [1:0] FACE_PLUS  = 2'd1;
    localparam logic [1:0] FACE_MINUS = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BA,
        S_BB,
        S_BW,
        S_SR,
        S_SC,
        S_WR,
        S_WC,
        S_HR,
        S_HC,
        S_CL,
        S_NEXT
    } t_state;

endpackage

### rtl/vgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vgm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/voxel_greedy_mesher.sv
// Voxel greedy mesher top level: sequencer, voxel store and face mask.
// Depends on vgm_pkg, vgm_ram and voxel_greedy_mesher_assert.svh.
//
// Usage: raise start with i_kind and payload; the transfer happens when busy
// is low. A load (kind 0) writes one solid bit into the bordered store in
// the same cycle and leaves busy low; out-of-range coordinates are dropped.
// A fetch (kind 1) returns one result: the next merged quad, or a done
// marker after the last quad of the walk, after which the walk restarts.
// The result shows for one cycle with o_res_valid; the receiver cannot stall.
// Work of a fetch: each slice mask build does two store reads and one mask
// write per cell through one store read port; scanning reads each mask cell
// visited, width and height growth read each cell tested, and clearing
// writes each covered cell, all through the single mask RAM port pair. One
// fetch may span several slice builds. Busy stays high until the result
// strobe.
// Reset: synchronous; afterwards a clearing pass writes every store entry
// to empty, with busy high.
module voxel_greedy_mesher #(
    parameter int CHUNK_SIZE = vgm_pkg::CHUNK_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [4:0]  i_vox_x,
    input  logic [4:0]  i_vox_y,
    input  logic [4:0]  i_vox_z,
    input  logic        i_solid,
    output logic        o_res_valid,
    output logic        o_done_res,
    output logic [1:0]  o_axis,
    output logic        o_facing,
    output logic [4:0]  o_plane,
    output logic [3:0]  o_u_start,
    output logic [3:0]  o_v_start,
    output logic [4:0]  o_quad_width,
    output logic [4:0]  o_quad_height,
    output logic [13:0] o_quad_number
);
    localparam int SPAN        = CHUNK_SIZE + 2;
    localparam int STORE_CELLS = SPAN * SPAN * SPAN;
    localparam int MASK_CELLS  = CHUNK_SIZE * CHUNK_SIZE;
    localparam int SW = $clog2(STORE_CELLS);
    localparam int MW = (MASK_CELLS > 1) ? $clog2(MASK_CELLS) : 1;
    localparam int MD = (MASK_CELLS > 1) ? MASK_CELLS : 2;
    localparam int IW = $clog2(CHUNK_SIZE + 1);
    localparam int PW = $clog2(CHUNK_SIZE + 2);

    vgm_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_clr, n_clr;
    logic [1:0]      r_axis, n_axis;
    logic [PW-1:0]   r_plane, n_plane;
    logic [IW-1:0]   r_si, n_si, r_sj, n_sj;
    logic [IW-1:0]   r_w, n_w, r_h, n_h, r_k, n_k, r_l, n_l;
    logic            r_ready, n_ready;
    logic [1:0]      r_cur, n_cur;
    logic            r_a, n_a;
    logic [13:0]     r_cnt, n_cnt;
    logic            r_valid, n_valid;
    logic            r_done, n_done;
    logic [1:0]      r_oaxis, n_oaxis;
    logic            r_ofacing, n_ofacing;
    logic [4:0]      r_oplane, n_oplane;
    logic [3:0]      r_ou, n_ou, r_ov, n_ov;
    logic [4:0]      r_ow, n_ow, r_oh, n_oh;
    logic [13:0]     r_onum, n_onum;

    logic            st_we, st_wdata, st_q;
    logic [SW-1:0]   st_waddr, st_raddr, ld_addr;
    logic            mk_we;
    logic [1:0]      mk_wdata, mk_q;
    logic [MW-1:0]   mk_waddr, mk_raddr;
    logic [IW:0]     mr_row, mr_col, mw_row, mw_col;
    logic [PW-1:0]   pd, pu, pv, px, py, pz;
    logic            ld_ok;
    logic [IW:0]     si_w, sj_h, sp_next;

    vgm_ram #(.WIDTH(1), .DEPTH(STORE_CELLS)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_q)
    );

    vgm_ram #(.WIDTH(2), .DEPTH(MD)) u_mask (
        .i_clk(i_clk), .i_we(mk_we), .i_waddr(mk_waddr), .i_wdata(mk_wdata),
        .i_raddr(mk_raddr), .o_rdata(mk_q)
    );

    // Store address of the current build cell, a or its neighbor b
    assign pd = (r_state == vgm_pkg::S_BB) ? PW'(r_plane + 1'b1) : r_plane;
    assign pu = PW'(r_si) + PW'(1);
    assign pv = PW'(r_sj) + PW'(1);

    always_comb begin
        unique case (r_axis)
            vgm_pkg::AXIS_Y: begin px = pv; py = pd; pz = pu; end
            vgm_pkg::AXIS_Z: begin px = pu; py = pv; pz = pd; end
            default:         begin px = pd; py = pu; pz = pv; end
        endcase
    end

    assign st_raddr = SW'((int'(pz) * SPAN + int'(py)) * SPAN + int'(px));
    assign ld_addr  = SW'((int'(i_vox_z) * SPAN + int'(i_vox_y)) * SPAN + int'(i_vox_x));
    assign ld_ok    = (int'(i_vox_x) < SPAN) && (int'(i_vox_y) < SPAN)
                   && (int'(i_vox_z) < SPAN);

    assign si_w    = {1'b0, r_si} + {1'b0, r_w};
    assign sj_h    = {1'b0, r_sj} + {1'b0, r_h};
    assign sp_next = si_w;

    assign mk_raddr = MW'(int'(mr_row) * CHUNK_SIZE + int'(mr_col));
    assign mk_waddr = MW'(int'(mw_row) * CHUNK_SIZE + int'(mw_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vgm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_axis  <= '0;
            r_plane <= '0;
            r_si    <= '0;
            r_sj    <= '0;
            r_ready <= 1'b0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_axis  <= n_axis;
            r_plane <= n_plane;
            r_si    <= n_si;
            r_sj    <= n_sj;
            r_ready <= n_ready;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_w       <= n_w;
        r_h       <= n_h;
        r_k       <= n_k;
        r_l       <= n_l;
        r_cur     <= n_cur;
        r_a       <= n_a;
        r_done    <= n_done;
        r_oaxis   <= n_oaxis;
        r_ofacing <= n_ofacing;
        r_oplane  <= n_oplane;
        r_ou      <= n_ou;
        r_ov      <= n_ov;
        r_ow      <= n_ow;
        r_oh      <= n_oh;
        r_onum    <= n_onum;
    end

    always_comb begin
        n_state = r_state;  n_clr = r_clr;     n_axis = r_axis;  n_plane = r_plane;
        n_si = r_si;        n_sj = r_sj;       n_w = r_w;        n_h = r_h;
        n_k = r_k;          n_l = r_l;         n_ready = r_ready; n_cur = r_cur;
        n_a = r_a;          n_cnt = r_cnt;     n_valid = 1'b0;   n_done = r_done;
        n_oaxis = r_oaxis;  n_ofacing = r_ofacing; n_oplane = r_oplane;
        n_ou = r_ou;        n_ov = r_ov;       n_ow = r_ow;      n_oh = r_oh;
        n_onum = r_onum;
        st_we = 1'b0;       st_waddr = ld_addr; st_wdata = i_solid;
        mk_we = 1'b0;       mk_wdata = vgm_pkg::FACE_NONE;
        mr_row = {1'b0, r_sj}; mr_col = {1'b0, r_si};
        mw_row = {1'b0, r_sj}; mw_col = {1'b0, r_si};

        unique case (r_state)
            vgm_pkg::S_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = 1'b0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == SW'(STORE_CELLS - 1)) begin
                    n_state = vgm_pkg::S_IDLE;
                end
            end
            vgm_pkg::S_IDLE: begin
                if (start) begin
                    if (i_kind == vgm_pkg::KIND_LOAD) begin
                        st_we = ld_ok;
                    end else if (r_ready) begin
                        n_state = vgm_pkg::S_SR;
                    end else begin
                        n_si    = '0;
                        n_sj    = '0;
                        n_state = vgm_pkg::S_BA;
                    end
                end
            end
            vgm_pkg::S_BA: n_state = vgm_pkg::S_BB;
            vgm_pkg::S_BB: begin
                n_a     = st_q;
                n_state = vgm_pkg::S_BW;
            end
            vgm_pkg::S_BW: begin
                mk_we = 1'b1;
                priority if (r_a && !st_q) begin
                    mk_wdata = vgm_pkg::FACE_PLUS;
                end else if (!r_a && st_q) begin
                    mk_wdata = vgm_pkg::FACE_MINUS;
                end else begin
                    mk_wdata = vgm_pkg::FACE_NONE;
                end
                n_state = vgm_pkg::S_BA;
                if (r_si == IW'(CHUNK_SIZE - 1)) begin
                    n_si = '0;
                    if (r_sj == IW'(CHUNK_SIZE - 1)) begin
                        n_sj    = '0;
                        n_ready = 1'b1;
                        n_state = vgm_pkg::S_SR;
                    end else begin
                        n_sj = r_sj + 1'b1;
                    end
                end else begin
                    n_si = r_si + 1'b1;
                end
            end
            vgm_pkg::S_SR: begin
                if (r_sj == IW'(CHUNK_SIZE)) begin
                    n_state = vgm_pkg::S_NEXT;
                end else begin
                    n_state = vgm_pkg::S_SC;
                end
            end
            vgm_pkg::S_SC: begin
                if (mk_q == vgm_pkg::FACE_NONE) begin
                    n_state = vgm_pkg::S_SR;
                    if (r_si == IW'(CHUNK_SIZE - 1)) begin
                        n_si = '0;
                        n_sj = r_sj + 1'b1;
                    end else begin
                        n_si = r_si + 1'b1;
                    end
                end else begin
                    n_cur   = mk_q;
                    n_w     = IW'(1);
                    n_state = vgm_pkg::S_WR;
                end
            end
            vgm_pkg::S_WR: begin
                mr_col = si_w;
                if (si_w < (IW+1)'(CHUNK_SIZE)) begin
                    n_state = vgm_pkg::S_WC;
                end else begin
                    n_h     = IW'(1);
                    n_k     = '0;
                    n_state = vgm_pkg::S_HR;
                end
            end
            vgm_pkg::S_WC: begin
                if (mk_q == r_cur) begin
                    n_w     = r_w + 1'b1;
                    n_state = vgm_pkg::S_WR;
                end else begin
                    n_h     = IW'(1);
                    n_k     = '0;
                    n_state = vgm_pkg::S_HR;
                end
            end
            vgm_pkg::S_HR: begin
                mr_row = sj_h;
                mr_col = {1'b0, r_si} + {1'b0, r_k};
                if (sj_h < (IW+1)'(CHUNK_SIZE)) begin
                    n_state = vgm_pkg::S_HC;
                end else begin
                    n_k     = '0;
                    n_l     = '0;
                    n_state = vgm_pkg::S_CL;
                end
            end
            vgm_pkg::S_HC: begin
                n_state = vgm_pkg::S_HR;
                if (mk_q != r_cur) begin
                    n_k     = '0;
                    n_l     = '0;
                    n_state = vgm_pkg::S_CL;
                end else if (r_k + 1'b1 == r_w) begin
                    n_k = '0;
                    n_h = r_h + 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            vgm_pkg::S_CL: begin
                mk_we  = 1'b1;
                mw_row = {1'b0, r_sj} + {1'b0, r_l};
                mw_col = {1'b0, r_si} + {1'b0, r_k};
                if (r_k + 1'b1 == r_w) begin
                    n_k = '0;
                    n_l = r_l + 1'b1;
                    if (r_l + 1'b1 == r_h) begin
                        // emit the quad and move the scan past it
                        n_valid   = 1'b1;
                        n_done    = 1'b0;
                        n_oaxis   = r_axis;
                        n_ofacing = (r_cur == vgm_pkg::FACE_PLUS);
                        n_oplane  = 5'(r_plane);
                        n_ou      = 4'(r_si);
                        n_ov      = 4'(r_sj);
                        n_ow      = 5'(r_w);
                        n_oh      = 5'(r_h);
                        n_onum    = r_cnt;
                        n_cnt     = r_cnt + 1'b1;
                        n_state   = vgm_pkg::S_IDLE;
                        if (sp_next == (IW+1)'(CHUNK_SIZE)) begin
                            n_si = '0;
                            n_sj = r_sj + 1'b1;
                        end else begin
                            n_si = IW'(sp_next);
                        end
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            vgm_pkg::S_NEXT: begin
                n_ready = 1'b0;
                n_si    = '0;
                n_sj    = '0;
                n_state = vgm_pkg::S_BA;
                if (r_plane == PW'(CHUNK_SIZE)) begin
                    n_plane = '0;
                    if (r_axis == vgm_pkg::AXIS_Z) begin
                        n_axis    = vgm_pkg::AXIS_X;
                        n_cnt     = '0;
                        n_valid   = 1'b1;
                        n_done    = 1'b1;
                        n_oaxis   = '0;
                        n_ofacing = 1'b0;
                        n_oplane  = '0;
                        n_ou      = '0;
                        n_ov      = '0;
                        n_ow      = '0;
                        n_oh      = '0;
                        n_onum    = '0;
                        n_state   = vgm_pkg::S_IDLE;
                    end else begin
                        n_axis = r_axis + 1'b1;
                    end
                end else begin
                    n_plane = r_plane + 1'b1;
                end
            end
            default: n_state = vgm_pkg::S_IDLE;
        endcase
    end

    assign busy          = (r_state != vgm_pkg::S_IDLE);
    assign o_res_valid   = r_valid;
    assign o_done_res    = r_done;
    assign o_axis        = r_oaxis;
    assign o_facing      = r_ofacing;
    assign o_plane       = r_oplane;
    assign o_u_start     = r_ou;
    assign o_v_start     = r_ov;
    assign o_quad_width  = r_ow;
    assign o_quad_height = r_oh;
    assign o_quad_number = r_onum;

`include "voxel_greedy_mesher_assert.svh"

    `VGM_ASSERT_NOW(a_res_idle, o_res_valid, !busy)
    `VGM_ASSERT_NOW(a_done_empty, o_res_valid && o_done_res, o_quad_width == 5'd0 && o_quad_number == 14'd0)
    `VGM_ASSERT_NOW(a_quad_size, o_res_valid && !o_done_res, o_quad_width != 5'd0 && o_quad_height != 5'd0)
    `VGM_ASSERT_NEXT(a_fetch_busy, start && !busy && i_kind, busy)
endmodule

### tb/testbench.sv
// Self-checking testbench for voxel_greedy_mesher: loads voxels, fetches quads until
// each walk is done, and compares every quad against a built-in greedy mesher.
// Depends on vgm_pkg and the voxel_greedy_mesher RTL.
module testbench;

    localparam int N       = 16;
    localparam int SPAN    = N + 2;
    localparam int CELLS   = SPAN * SPAN * SPAN;
    localparam int LIMIT   = 4_000_000;
    localparam int TARGET  = 1050;

    typedef struct packed {
        logic        done_res;
        logic [1:0]  axis;
        logic        facing;
        logic [4:0]  plane;
        logic [3:0]  u_start;
        logic [3:0]  v_start;
        logic [4:0]  quad_width;
        logic [4:0]  quad_height;
        logic [13:0] quad_number;
    } t_mesh_quad;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = vgm_pkg::KIND_LOAD;
    logic [4:0]  i_vox_x = '0;
    logic [4:0]  i_vox_y = '0;
    logic [4:0]  i_vox_z = '0;
    logic        i_solid = 1'b0;
    logic        o_res_valid;
    logic        o_done_res;
    logic [1:0]  o_axis;
    logic        o_facing;
    logic [4:0]  o_plane;
    logic [3:0]  o_u_start;
    logic [3:0]  o_v_start;
    logic [4:0]  o_quad_width;
    logic [4:0]  o_quad_height;
    logic [13:0] o_quad_number;

    voxel_greedy_mesher u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_vox_x(i_vox_x), .i_vox_y(i_vox_y), .i_vox_z(i_vox_z),
        .i_solid(i_solid), .o_res_valid(o_res_valid), .o_done_res(o_done_res),
        .o_axis(o_axis), .o_facing(o_facing), .o_plane(o_plane),
        .o_u_start(o_u_start), .o_v_start(o_v_start), .o_quad_width(o_quad_width),
        .o_quad_height(o_quad_height), .o_quad_number(o_quad_number)
    );

    always #5 i_clk = ~i_clk;

    // Mesher shadow state
    bit          solid_cells [CELLS];
    logic [1:0]  slice_faces [N*N];
    int          cur_axis;
    int          cur_slice;
    int          scan_at;
    bit          faces_built;
    logic [13:0] quad_count;

    t_mesh_quad  expected_quads [$];
    bit          failed = 1'b0;
    bit          idle_on = 1'b1;
    bit          walk_done;
    int          item_count = 0;
    int          cycle_count = 0;

    function automatic int cell_index(int x, int y, int z);
        return (z * SPAN + y) * SPAN + x;
    endfunction

    task automatic build_faces();
        int p[3];
        int u;
        int v;
        bit a;
        bit b;
        u = (cur_axis + 1) % 3;
        v = (cur_axis + 2) % 3;
        for (int j = 0; j < N; j++) begin
            for (int i = 0; i < N; i++) begin
                p[cur_axis] = cur_slice + 1;
                p[u] = i + 1;
                p[v] = j + 1;
                a = solid_cells[cell_index(p[0], p[1], p[2])];
                p[cur_axis] += 1;
                b = solid_cells[cell_index(p[0], p[1], p[2])];
                slice_faces[j*N + i] = (a && !b) ? vgm_pkg::FACE_PLUS :
                                       (!a && b) ? vgm_pkg::FACE_MINUS : vgm_pkg::FACE_NONE;
            end
        end
        faces_built = 1'b1;
        scan_at = 0;
    endtask

    task automatic next_quad(output t_mesh_quad q);
        logic [1:0] cur;
        int w;
        int h;
        bit stop;
        forever begin
            if (!faces_built) build_faces();
            for (int n = scan_at; n < N*N; n++) begin
                cur = slice_faces[n];
                if (cur == vgm_pkg::FACE_NONE) continue;
                w = 1;
                while ((n % N) + w < N && slice_faces[n + w] == cur) w++;
                stop = 1'b0;
                for (h = 1; (n / N) + h < N; h++) begin
                    for (int k = 0; k < w; k++)
                        if (slice_faces[n + k + h*N] != cur) stop = 1'b1;
                    if (stop) break;
                end
                for (int l = 0; l < h; l++)
                    for (int k = 0; k < w; k++)
                        slice_faces[n + k + l*N] = vgm_pkg::FACE_NONE;
                scan_at = n + w;
                q = '0;
                q.axis = cur_axis[1:0];
                q.facing = (cur == vgm_pkg::FACE_PLUS);
                q.plane = 5'(cur_slice + 1);
                q.u_start = 4'(n % N);
                q.v_start = 4'(n / N);
                q.quad_width = 5'(w);
                q.quad_height = 5'(h);
                q.quad_number = quad_count;
                quad_count++;
                return;
            end
            faces_built = 1'b0;
            cur_slice++;
            if (cur_slice >= N) begin
                cur_slice = -1;
                cur_axis++;
                if (cur_axis > 2) begin
                    cur_axis = 0;
                    quad_count = '0;
                    scan_at = 0;
                    q = '0;
                    q.done_res = 1'b1;
                    return;
                end
            end
        end
    endtask

    // Leaves start high; the caller either sends again or lowers it.
    task automatic send_item(logic kind, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                             logic s);
        t_mesh_quad q;
        start <= 1'b1;
        i_kind <= kind;
        i_vox_x <= x;
        i_vox_y <= y;
        i_vox_z <= z;
        i_solid <= s;
        do @(posedge i_clk); while (busy);
        item_count++;
        if (kind == vgm_pkg::KIND_LOAD) begin
            if (x < SPAN && y < SPAN && z < SPAN) solid_cells[cell_index(x, y, z)] = s;
        end else begin
            next_quad(q);
            walk_done = q.done_res;
            expected_quads.push_back(q);
        end
    endtask

    task automatic load_voxel(int x, int y, int z, bit s);
        send_item(vgm_pkg::KIND_LOAD, 5'(x), 5'(y), 5'(z), s);
    endtask

    task automatic fetch_quad();
        send_item(vgm_pkg::KIND_FETCH, 5'($urandom), 5'($urandom), 5'($urandom),
                  1'($urandom));
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_quads.size() != 0) @(posedge i_clk);
    endtask

    task automatic fetch_whole_walk(bit mix_loads);
        do begin
            // Loads mid-walk only affect slices not yet built.
            if (mix_loads && $urandom_range(0, 9) == 0)
                load_voxel($urandom_range(0, 17), $urandom_range(0, 17),
                           $urandom_range(0, 17), 1'($urandom));
            fetch_quad();
            maybe_idle();
        end while (!walk_done);
    endtask

    task automatic fill_box();
        int x0, y0, z0, sx, sy, sz;
        bit s;
        x0 = $urandom_range(0, 17);
        y0 = $urandom_range(0, 17);
        z0 = $urandom_range(0, 17);
        sx = $urandom_range(1, 4);
        sy = $urandom_range(1, 4);
        sz = $urandom_range(1, 4);
        s = ($urandom_range(0, 4) != 0);
        for (int z = z0; z < z0 + sz && z < SPAN; z++)
            for (int y = y0; y < y0 + sy && y < SPAN; y++)
                for (int x = x0; x < x0 + sx && x < SPAN; x++) begin
                    load_voxel(x, y, z, s);
                    maybe_idle();
                end
    endtask

    task automatic test_empty_chunk();
        fetch_quad();
        drain_results();
    endtask

    task automatic test_extremes();
        load_voxel(0, 0, 0, 1'b1);
        load_voxel(17, 17, 17, 1'b1);
        load_voxel(31, 31, 31, 1'b1);
        load_voxel(18, 1, 1, 1'b1);
        load_voxel(1, 18, 1, 1'b1);
        load_voxel(1, 1, 18, 1'b1);
        load_voxel(1, 1, 1, 1'b1);
        load_voxel(16, 16, 16, 1'b1);
        load_voxel(16, 1, 16, 1'b1);
        load_voxel(16, 1, 16, 1'b0);
        load_voxel(17, 8, 8, 1'b1);
        load_voxel(16, 8, 8, 1'b1);
        load_voxel(0, 4, 4, 1'b1);
        fetch_whole_walk(1'b0);
        drain_results();
    endtask

    task automatic test_random_walks();
        int walks;
        walks = 0;
        while (item_count < TARGET && walks < 32) begin
            if (item_count > TARGET - 200) idle_on = 1'b0;
            repeat ($urandom_range(1, 4)) fill_box();
            repeat ($urandom_range(10, 30)) begin
                load_voxel($urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31), 1'($urandom));
                maybe_idle();
            end
            fetch_whole_walk(1'b1);
            walks++;
        end
    endtask

    always @(posedge i_clk) begin
        t_mesh_quad exp_q;
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else if (i_rst_n && o_res_valid) begin
            if (expected_quads.size() == 0) begin
                $display("%0t: unexpected result done=%0d", $time, o_done_res);
                failed = 1'b1;
            end else begin
                exp_q = expected_quads.pop_front();
                if (o_done_res !== exp_q.done_res) begin
                    $display("%0t: done exp %0d got %0d", $time, exp_q.done_res, o_done_res);
                    failed = 1'b1;
                end
                if (o_axis !== exp_q.axis) begin
                    $display("%0t: axis exp %0d got %0d", $time, exp_q.axis, o_axis);
                    failed = 1'b1;
                end
                if (o_facing !== exp_q.facing) begin
                    $display("%0t: facing exp %0d got %0d", $time, exp_q.facing, o_facing);
                    failed = 1'b1;
                end
                if (o_plane !== exp_q.plane) begin
                    $display("%0t: plane exp %0d got %0d", $time, exp_q.plane, o_plane);
                    failed = 1'b1;
                end
                if (o_u_start !== exp_q.u_start) begin
                    $display("%0t: u_start exp %0d got %0d", $time, exp_q.u_start, o_u_start);
                    failed = 1'b1;
                end
                if (o_v_start !== exp_q.v_start) begin
                    $display("%0t: v_start exp %0d got %0d", $time, exp_q.v_start, o_v_start);
                    failed = 1'b1;
                end
                if (o_quad_width !== exp_q.quad_width) begin
                    $display("%0t: width exp %0d got %0d", $time, exp_q.quad_width,
                             o_quad_width);
                    failed = 1'b1;
                end
                if (o_quad_height !== exp_q.quad_height) begin
                    $display("%0t: height exp %0d got %0d", $time, exp_q.quad_height,
                             o_quad_height);
                    failed = 1'b1;
                end
                if (o_quad_number !== exp_q.quad_number) begin
                    $display("%0t: number exp %0d got %0d", $time, exp_q.quad_number,
                             o_quad_number);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        foreach (solid_cells[k]) solid_cells[k] = 1'b0;
        cur_axis = 0;
        cur_slice = -1;
        scan_at = 0;
        faces_built = 1'b0;
        quad_count = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_chunk();
        test_extremes();
        test_random_walks();
        drain_results();
        repeat (50) @(posedge i_clk);
        if (!failed) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
